// ===== hw/rtl/nie_pkg.sv =====
// shared constants, types and helpers for the newton interpolation engine
`timescale 1ns / 1ps
package nie_pkg;

    localparam int MAX_NODES = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int TOL_W     = 31;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int DIVD_W    = DATA_W + FRAC_BITS;
    localparam int DIVS_W    = DATA_W + 1;
    localparam int DCNT_W    = $clog2(DIVD_W);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ADDR_W    = 3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SINGULAR  = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_RD,
        S_B_CHK,
        S_B_DIV,
        S_E_INIT,
        S_E_LD,
        S_E_RD,
        S_E_SUB,
        S_E_MUL,
        S_E_ACC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             wr_load;
        logic [IDX_W-1:0] load_addr;
        logic [IDX_W-1:0] rd_i;
        logic [IDX_W-1:0] rd_ik;
        logic [IDX_W-1:0] rd_im1;
        logic             bld_chk;
        logic             bld_wr;
        logic             cap_z;
        logic             ev_init;
        logic             ev_sub;
        logic             ev_mul;
        logic             ev_acc;
    } t_dp_cmd;

    typedef struct packed {
        logic singular;
        logic div_done;
    } t_dp_sts;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/newton_interpolation_engine.sv =====
// newton interpolation engine top level: register port, sequencer and datapath
// load beat without last mark: no result; busy stays low
// build: no division for a single node, else n(n+1)/2 division steps for n+1 nodes,
// each done by the one-bit-per-cycle restoring divider over a 48-bit dividend
// evaluate: n horner steps for n+1 coefficients on the shared multiply-add
// synchronous active-low reset clears control state; stores are undefined until loaded
`timescale 1ns / 1ps
module newton_interpolation_engine
    import nie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_action,
    input  logic signed [DATA_W-1:0] i_node_x,
    input  logic signed [DATA_W-1:0] i_sample_f,
    input  logic                     i_last_node,
    input  logic signed [DATA_W-1:0] i_eval_point,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic signed [DATA_W-1:0] o_poly_value,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [TOL_W-1:0]         r_tol;
    t_dp_cmd                  cmd;
    t_dp_sts                  sts;
    logic                     val_ok;
    logic signed [DATA_W-1:0] poly;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == 1'b0) ? {1'b0, r_tol} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == 1'b0) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    nie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (i_action),
        .i_last_node (i_last_node),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_val_ok    (val_ok)
    );

    nie_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_node_x     (i_node_x),
        .i_sample_f   (i_sample_f),
        .i_eval_point (i_eval_point),
        .i_tolerance  (r_tol),
        .o_sts        (sts),
        .o_poly       (poly)
    );

    assign o_poly_value = val_ok ? poly : '0;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat while idle");
    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_poly_value != '0) |-> (o_valid && o_status == ST_OK))
        else $error("nonzero value outside a good evaluate beat");
`endif

endmodule

// ===== hw/rtl/nie_ctrl.sv =====
// sequencer for loading, coefficient build and horner evaluation
`timescale 1ns / 1ps
module nie_ctrl
    import nie_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_action,
    input  logic          i_last_node,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic          o_val_ok
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             r_ready;
    logic [IDX_W-1:0] r_ready_n;
    logic [IDX_W-1:0] r_n, r_k, r_i;
    logic [1:0]       r_status;
    logic             r_is_eval;
    logic             accept;
    logic             room;

    assign accept = i_start && (r_state == S_IDLE);
    assign room   = r_cnt < CNT_W'(MAX_NODES);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_EVAL) begin
                        n_state = r_ready ? S_E_INIT : S_DONE;
                    end else if (i_last_node) begin
                        if (r_ovf || !room || r_cnt == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_B_RD;
                        end
                    end
                end
            end
            S_B_RD:   n_state = S_B_CHK;
            S_B_CHK:  n_state = i_sts.singular ? S_DONE : S_B_DIV;
            S_B_DIV: begin
                if (i_sts.div_done) begin
                    n_state = (r_i == r_k && r_k == r_n) ? S_DONE : S_B_RD;
                end
            end
            S_E_INIT: n_state = S_E_LD;
            S_E_LD:   n_state = (r_i == '0) ? S_DONE : S_E_RD;
            S_E_RD:   n_state = S_E_SUB;
            S_E_SUB:  n_state = S_E_MUL;
            S_E_MUL:  n_state = S_E_ACC;
            S_E_ACC:  n_state = (r_i == '0) ? S_DONE : S_E_RD;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_load   = accept && (i_action == ACT_LOAD) && room;
        o_cmd.load_addr = r_cnt[IDX_W-1:0];
        o_cmd.rd_i      = r_i;
        o_cmd.rd_ik     = r_i - r_k;
        o_cmd.rd_im1    = r_i - IDX_W'(1);
        o_cmd.bld_chk   = (r_state == S_B_CHK);
        o_cmd.bld_wr    = (r_state == S_B_DIV) && i_sts.div_done;
        o_cmd.cap_z     = accept && (i_action == ACT_EVAL);
        o_cmd.ev_init   = (r_state == S_E_LD);
        o_cmd.ev_sub    = (r_state == S_E_SUB);
        o_cmd.ev_mul    = (r_state == S_E_MUL);
        o_cmd.ev_acc    = (r_state == S_E_ACC);
        o_busy          = (r_state != S_IDLE);
        o_valid         = (r_state == S_DONE);
        o_status        = r_status;
        o_val_ok        = (r_state == S_DONE) && r_is_eval && (r_status == ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_ready   <= 1'b0;
            r_ready_n <= '0;
            r_n       <= '0;
            r_k       <= '0;
            r_i       <= '0;
            r_status  <= ST_OK;
            r_is_eval <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_action == ACT_EVAL) begin
                        r_is_eval <= 1'b1;
                        r_i       <= r_ready_n;
                        r_status  <= r_ready ? ST_OK : ST_NOT_READY;
                    end else if (accept) begin
                        r_ready <= 1'b0;
                        if (room) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_node) begin
                            r_cnt     <= '0;
                            r_ovf     <= 1'b0;
                            r_is_eval <= 1'b0;
                            r_n       <= r_cnt[IDX_W-1:0];
                            r_k       <= IDX_W'(1);
                            r_i       <= r_cnt[IDX_W-1:0];
                            if (r_ovf || !room) begin
                                r_status <= ST_TOO_MANY;
                            end else begin
                                r_status <= ST_OK;
                                if (r_cnt == '0) begin
                                    r_ready   <= 1'b1;
                                    r_ready_n <= '0;
                                end
                            end
                        end
                    end
                end
                S_B_CHK: begin
                    if (i_sts.singular) begin
                        r_status <= ST_SINGULAR;
                    end
                end
                S_B_DIV: begin
                    if (i_sts.div_done) begin
                        if (r_i == r_k) begin
                            if (r_k == r_n) begin
                                r_status  <= ST_OK;
                                r_ready   <= 1'b1;
                                r_ready_n <= r_n;
                            end else begin
                                r_k <= r_k + IDX_W'(1);
                                r_i <= r_n;
                            end
                        end else begin
                            r_i <= r_i - IDX_W'(1);
                        end
                    end
                end
                S_E_LD, S_E_ACC: begin
                    if (r_i != '0) begin
                        r_i <= r_i - IDX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/nie_datapath.sv =====
// node and coefficient stores, divided-difference divider and horner multiply-add
`timescale 1ns / 1ps
module nie_datapath
    import nie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_node_x,
    input  logic signed [DATA_W-1:0] i_sample_f,
    input  logic signed [DATA_W-1:0] i_eval_point,
    input  logic [TOL_W-1:0]         i_tolerance,
    output t_dp_sts                  o_sts,
    output logic signed [DATA_W-1:0] o_poly
);

    logic signed [DATA_W-1:0] node_mem  [MAX_NODES];
    logic signed [DATA_W-1:0] coeff_mem [MAX_NODES];
    logic signed [DATA_W-1:0] r_x_a, r_x_b, r_c_a, r_c_b;

    logic signed [DATA_W-1:0] r_z, r_d, r_p;
    logic signed [PROD_W-1:0] r_prod;

    logic [DIVD_W-1:0]        r_dq;
    logic [DIVS_W-1:0]        r_rem;
    logic [DIVS_W-1:0]        r_dmag;
    logic [DCNT_W-1:0]        r_dcnt;
    logic                     r_div_act;
    logic                     r_neg;

    logic signed [DIVS_W-1:0] den;
    logic [DIVS_W-1:0]        den_mag;
    logic signed [DATA_W-1:0] diff;
    logic [DATA_W-1:0]        diff_mag;
    logic                     singular;
    logic [DIVS_W:0]          rem_sh;
    logic                     fits;
    logic signed [DATA_W-1:0] quot;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] scaled;

    assign den      = DIVS_W'(r_x_a) - DIVS_W'(r_x_b);
    assign den_mag  = den[DIVS_W-1] ? DIVS_W'(-den) : DIVS_W'(den);
    assign singular = (den == '0) || (den_mag < DIVS_W'(i_tolerance));
    assign diff     = sat_data(SUM_W'(r_c_a) - SUM_W'(r_c_b));
    assign diff_mag = diff[DATA_W-1] ? DATA_W'(-diff) : DATA_W'(diff);

    assign rem_sh   = {r_rem, r_dq[DIVD_W-1]};
    assign fits     = rem_sh >= {1'b0, r_dmag};

    always_comb begin
        if (!r_neg) begin
            if (r_dq[DIVD_W-1:DATA_W-1] != '0) begin
                quot = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                quot = r_dq[DATA_W-1:0];
            end
        end else begin
            if (r_dq > DIVD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
                quot = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                quot = -r_dq[DATA_W-1:0];
            end
        end
    end

    assign biased = r_prod + (r_prod[PROD_W-1] ? PROD_W'({FRAC_BITS{1'b1}}) : '0);
    assign scaled = biased >>> FRAC_BITS;

    assign o_sts.singular = singular;
    assign o_sts.div_done = !r_div_act;
    assign o_poly         = r_p;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load) begin
            node_mem[i_cmd.load_addr] <= i_node_x;
        end
        r_x_a <= node_mem[i_cmd.rd_i];
        r_x_b <= node_mem[i_cmd.rd_ik];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load) begin
            coeff_mem[i_cmd.load_addr] <= i_sample_f;
        end else if (i_cmd.bld_wr) begin
            coeff_mem[i_cmd.rd_i] <= quot;
        end
        r_c_a <= coeff_mem[i_cmd.rd_i];
        r_c_b <= coeff_mem[i_cmd.rd_im1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_act <= 1'b0;
            r_dcnt    <= '0;
        end else if (i_cmd.bld_chk && !singular) begin
            r_div_act <= 1'b1;
            r_dcnt    <= DCNT_W'(DIVD_W - 1);
        end else if (r_div_act) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
            if (r_dcnt == '0) begin
                r_div_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bld_chk) begin
            r_dq   <= {diff_mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_dmag <= den_mag;
            r_neg  <= diff[DATA_W-1] ^ den[DIVS_W-1];
        end else if (r_div_act) begin
            r_dq  <= {r_dq[DIVD_W-2:0], fits};
            r_rem <= fits ? DIVS_W'(rem_sh - {1'b0, r_dmag}) : rem_sh[DIVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_z) begin
            r_z <= i_eval_point;
        end
        if (i_cmd.ev_init) begin
            r_p <= r_c_a;
        end
        if (i_cmd.ev_sub) begin
            r_d <= sat_data(SUM_W'(r_z) - SUM_W'(r_x_a));
        end
        if (i_cmd.ev_mul) begin
            r_prod <= PROD_W'(r_p) * PROD_W'(r_d);
        end
        if (i_cmd.ev_acc) begin
            r_p <= sat_data(SUM_W'(scaled) + SUM_W'(r_c_a));
        end
    end

endmodule
